// File: sv/rvmls_pkg.sv
// Shared types and constants for the RV32 byte-addressed data memory.
// Used by rvmls_bank and rv32_byte_memory_load_store; depends on nothing.
package rvmls_pkg;

    localparam int MEM_BYTES = 4096;
    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int NBANK     = 4;
    localparam int ROW_W     = ADDR_W - 2;
    localparam int ROWS      = MEM_BYTES / NBANK;

    localparam int IN_W  = 72;
    localparam int OUT_W = 40;

    typedef enum logic [1:0] {
        CMD_IDLE  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_STORE = 2'd2,
        CMD_BOTH  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FUNCT    = 2'd2,
        ST_CONFLICT = 2'd3
    } status_t;

    localparam logic [2:0] F3_B  = 3'b000;
    localparam logic [2:0] F3_H  = 3'b001;
    localparam logic [2:0] F3_W  = 3'b010;
    localparam logic [2:0] F3_BU = 3'b100;
    localparam logic [2:0] F3_HU = 3'b101;

    // One access to one byte lane.
    typedef struct packed {
        logic             we;
        logic             re;
        logic [ROW_W-1:0] row;
        logic [7:0]       wdata;
    } bank_req_t;

endpackage

// File: sv/rvmls_bank.sv
// One byte lane of the data memory: a synchronous single-port RAM with
// registered read data. Depends on rvmls_pkg for the request type and depth.
module rvmls_bank
(
    input  logic                 clk,
    input  rvmls_pkg::bank_req_t req,
    output logic [7:0]           rdata
);

    logic [7:0] mem [rvmls_pkg::ROWS];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.row] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.row];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/rv32_byte_memory_load_store.sv
// Top level of the RV32I data memory: request decode, four byte-lane banks,
// load data alignment and the output register. Depends on rvmls_pkg, rvmls_bank.

// The memory holds 4096 bytes in four byte-wide banks of 1024 rows, so any
// aligned or unaligned access of up to four bytes touches each bank at most
// once. After reset the block clears the banks, one row per cycle, with
// s_tready held low. From then on it takes one transaction per cycle while
// the output is not held by m_tready; the result of a transaction passes
// through the bank read data and the read-stage registers, and is then
// aligned and extended into the output register.
// Errored requests write nothing and return a load_value of zero.
module rv32_byte_memory_load_store
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[1:0], funct3[4:2], byte_address[36:5], store_value[68:37], zero fill
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // load_value[31:0], status[33:32], zero fill
    output logic [39:0] m_tdata
);

    localparam int NB = rvmls_pkg::NBANK;
    localparam int AW = rvmls_pkg::ADDR_W;
    localparam int RW = rvmls_pkg::ROW_W;

    // Input decode
    rvmls_pkg::cmd_t    in_cmd;
    logic [2:0]         in_f3;
    logic [31:0]        in_addr;
    logic [31:0]        in_data;
    logic [2:0]         in_nbytes;
    logic [32:0]        end_sum;
    rvmls_pkg::status_t in_status;
    logic               s_accept;
    logic               do_write;
    logic               do_read;

    // Banks
    rvmls_pkg::bank_req_t bank_req [NB];
    logic [7:0]           bank_rdata [NB];
    logic [1:0]           lane_idx [NB];
    logic [AW-1:0]        lane_addr [NB];

    // Clearing pass
    logic          clearing_reg;
    logic          clearing_next;
    logic [RW-1:0] clr_row_reg;
    logic [RW-1:0] clr_row_next;

    // Read stage
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_load_reg;
    rvmls_pkg::status_t s1_status_reg;
    logic [2:0]         s1_f3_reg;
    logic [2:0]         s1_nbytes_reg;
    logic [1:0]         s1_shift_reg;

    // Output stage
    logic               out_free;
    logic               s1_move;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [31:0]        out_value_reg;
    rvmls_pkg::status_t out_status_reg;
    logic [31:0]        raw_value;
    logic [31:0]        ext_value;
    logic [1:0]         rd_lane;

    assign in_cmd  = rvmls_pkg::cmd_t'(s_tdata[1:0]);
    assign in_f3   = s_tdata[4:2];
    assign in_addr = s_tdata[36:5];
    assign in_data = s_tdata[68:37];

    assign out_free = !out_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_tready = !clearing_reg && (!s1_valid_reg || out_free);
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        unique case (in_f3)
            rvmls_pkg::F3_B:  in_nbytes = 3'd1;
            rvmls_pkg::F3_H:  in_nbytes = 3'd2;
            rvmls_pkg::F3_W:  in_nbytes = 3'd4;
            rvmls_pkg::F3_BU: in_nbytes = (in_cmd == rvmls_pkg::CMD_STORE) ? 3'd0 : 3'd1;
            rvmls_pkg::F3_HU: in_nbytes = (in_cmd == rvmls_pkg::CMD_STORE) ? 3'd0 : 3'd2;
            default:          in_nbytes = 3'd0;
        endcase
    end

    assign end_sum = {1'b0, in_addr} + 33'(in_nbytes);

    always_comb
    begin
        if (in_cmd == rvmls_pkg::CMD_BOTH)
        begin
            in_status = rvmls_pkg::ST_CONFLICT;
        end
        else if (in_cmd == rvmls_pkg::CMD_IDLE)
        begin
            in_status = rvmls_pkg::ST_OK;
        end
        else if (in_nbytes == 3'd0)
        begin
            in_status = rvmls_pkg::ST_FUNCT;
        end
        else if (end_sum > 33'(rvmls_pkg::MEM_BYTES))
        begin
            in_status = rvmls_pkg::ST_RANGE;
        end
        else
        begin
            in_status = rvmls_pkg::ST_OK;
        end
    end

    assign do_write = s_accept && (in_cmd == rvmls_pkg::CMD_STORE)
                      && (in_status == rvmls_pkg::ST_OK);
    assign do_read  = s_accept && (in_cmd == rvmls_pkg::CMD_LOAD)
                      && (in_status == rvmls_pkg::ST_OK);

    // Bank b holds the bytes whose address is b modulo four; it serves byte
    // (b - addr) mod 4 of the access, which wraps into the next row as needed.
    always_comb
    begin
        for (int b = 0; b < NB; b++)
        begin
            lane_idx[b]  = 2'(b) - in_addr[1:0];
            lane_addr[b] = in_addr[AW-1:0] + AW'(lane_idx[b]);
            if (clearing_reg)
            begin
                bank_req[b].we    = 1'b1;
                bank_req[b].re    = 1'b0;
                bank_req[b].row   = clr_row_reg;
                bank_req[b].wdata = 8'd0;
            end
            else
            begin
                bank_req[b].we    = do_write && ({1'b0, lane_idx[b]} < in_nbytes);
                bank_req[b].re    = do_read;
                bank_req[b].row   = lane_addr[b][AW-1:2];
                bank_req[b].wdata = 8'(in_data >> {lane_idx[b], 3'b000});
            end
        end
    end

    for (genvar g = 0; g < NB; g++)
    begin : g_bank
        rvmls_bank u_bank
        (
            .clk   (clk),
            .req   (bank_req[g]),
            .rdata (bank_rdata[g])
        );
    end

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_row_next  = clr_row_reg;
        if (clearing_reg)
        begin
            clr_row_next = clr_row_reg + 1'b1;
            if (clr_row_reg == RW'(rvmls_pkg::ROWS - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    // Gather the bytes of a load back into order and extend them.
    always_comb
    begin
        raw_value = 32'd0;
        rd_lane   = 2'd0;
        for (int i = 0; i < NB; i++)
        begin
            rd_lane = s1_shift_reg + 2'(i);
            if (3'(i) < s1_nbytes_reg)
            begin
                raw_value[8*i +: 8] = bank_rdata[rd_lane];
            end
        end
        ext_value = raw_value;
        if (s1_f3_reg == rvmls_pkg::F3_B)
        begin
            ext_value = {{24{raw_value[7]}}, raw_value[7:0]};
        end
        else if (s1_f3_reg == rvmls_pkg::F3_H)
        begin
            ext_value = {{16{raw_value[15]}}, raw_value[15:0]};
        end
        if (!s1_load_reg)
        begin
            ext_value = 32'd0;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_row_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_row_reg   <= clr_row_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_load_reg   <= do_read;
            s1_status_reg <= in_status;
            s1_f3_reg     <= in_f3;
            s1_nbytes_reg <= in_nbytes;
            s1_shift_reg  <= in_addr[1:0];
        end
        if (s1_move)
        begin
            out_value_reg  <= ext_value;
            out_status_reg <= s1_status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_status_reg, out_value_reg};

    // No transaction is taken while the banks are being cleared.
    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s_tready)
        else $error("transaction accepted during clearing pass");

    // A request that ends in an error never writes a bank.
    a_no_write_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && in_status != rvmls_pkg::ST_OK)
        |-> !(bank_req[0].we || bank_req[1].we || bank_req[2].we || bank_req[3].we))
        else $error("bank written by an errored request");

    // Errored results carry zero data.
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != rvmls_pkg::ST_OK) |-> (out_value_reg == 32'd0))
        else $error("non-zero load_value with error status");

    // A pending read-stage item is not lost while the output is blocked.
    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(s1_status_reg)))
        else $error("read stage dropped while output stalled");

    // Bank 0 is only read or written for accepted requests once clearing ends.
    a_bank_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!clearing_reg && !s_accept) |-> !(bank_req[0].we || bank_req[0].re))
        else $error("bank access without a transaction");

endmodule

// File: dv/tb_rv32_byte_memory_load_store.sv
// Self-checking testbench for the RV32I byte-addressed data memory.
// Drives load and store transactions into rv32_byte_memory_load_store and checks
// every result against a byte-level memory image kept here; depends on rvmls_pkg.
module tb_rv32_byte_memory_load_store;

    localparam int unsigned N_DIRECTED   = 25;
    localparam int unsigned N_RANDOM     = 1625;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned REPORT_MAX   = 10;
    localparam int unsigned MODE_SPAN    = 40;

    // Width codes that no RV32I load or store uses.
    localparam logic [2:0] F3_RSVD3 = 3'b011;
    localparam logic [2:0] F3_RSVD6 = 3'b110;
    localparam logic [2:0] F3_RSVD7 = 3'b111;

    typedef struct packed {
        rvmls_pkg::cmd_t    cmd;
        logic [2:0]         f3;
        logic [31:0]        addr;
        logic [31:0]        wdata;
        logic               fixed_exp;
        logic [31:0]        exp_value;
        rvmls_pkg::status_t exp_status;
    } access_row_t;

    typedef struct {
        logic [31:0]        value;
        rvmls_pkg::status_t status;
    } mem_result_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;

    logic [7:0]  mem_image [rvmls_pkg::MEM_BYTES];
    mem_result_t expected_results [$];

    int unsigned cycle_count    = 0;
    int unsigned mismatches     = 0;
    int unsigned results_seen   = 0;
    int unsigned items_sent     = 0;
    int unsigned status_count [4];
    int unsigned cmd_count [4];
    bit          sender_calm    = 1'b0;
    bit          receiver_calm  = 1'b0;

    rv32_byte_memory_load_store dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Byte-level image of the data memory; updates it for stores and works out the
    // load data and status that one transaction should return.
    function automatic void predict_access(input rvmls_pkg::cmd_t cmd,
                                           input logic [2:0] f3,
                                           input logic [31:0] addr,
                                           input logic [31:0] wdata,
                                           output logic [31:0] value,
                                           output rvmls_pkg::status_t status);
        int unsigned nbytes;
        bit          is_store;
        value  = '0;
        status = rvmls_pkg::ST_OK;
        nbytes = 0;
        if (cmd == rvmls_pkg::CMD_BOTH)
        begin
            status = rvmls_pkg::ST_CONFLICT;
        end
        else if (cmd != rvmls_pkg::CMD_IDLE)
        begin
            is_store = (cmd == rvmls_pkg::CMD_STORE);
            case (f3)
                rvmls_pkg::F3_B:  nbytes = 1;
                rvmls_pkg::F3_H:  nbytes = 2;
                rvmls_pkg::F3_W:  nbytes = 4;
                rvmls_pkg::F3_BU: nbytes = is_store ? 0 : 1;
                rvmls_pkg::F3_HU: nbytes = is_store ? 0 : 2;
                default:          nbytes = 0;
            endcase
            if (nbytes == 0)
            begin
                status = rvmls_pkg::ST_FUNCT;
            end
            else if (64'(addr) + 64'(nbytes) > 64'(rvmls_pkg::MEM_BYTES))
            begin
                // The address does not wrap, so an access straddling the top
                // is refused whole.
                status = rvmls_pkg::ST_RANGE;
            end
            else if (is_store)
            begin
                for (int i = 0; i < nbytes; i++)
                    mem_image[int'(addr) + i] = wdata[8*i +: 8];
            end
            else
            begin
                for (int i = 0; i < nbytes; i++)
                    value[8*i +: 8] = mem_image[int'(addr) + i];
                if (f3 == rvmls_pkg::F3_B && value[7])
                    value[31:8] = '1;
                else if (f3 == rvmls_pkg::F3_H && value[15])
                    value[31:16] = '1;
            end
        end
    endfunction

    function automatic int unsigned draw_wait(input bit calm);
        if (calm)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 18);
        return $urandom_range(0, 2);
    endfunction

    // Mostly well-formed accesses, many in a small window at either end of the memory
    // so that loads read back earlier stores; the rest is error traffic.
    function automatic access_row_t random_access();
        access_row_t row;
        int unsigned roll;
        row  = '0;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            row.cmd = rvmls_pkg::CMD_LOAD;
        else if (roll < 85)
            row.cmd = rvmls_pkg::CMD_STORE;
        else if (roll < 92)
            row.cmd = rvmls_pkg::CMD_IDLE;
        else
            row.cmd = rvmls_pkg::CMD_BOTH;
        if ($urandom_range(0, 99) < 88)
        begin
            case ($urandom_range(0, (row.cmd == rvmls_pkg::CMD_STORE) ? 2 : 4))
                0:       row.f3 = rvmls_pkg::F3_B;
                1:       row.f3 = rvmls_pkg::F3_H;
                2:       row.f3 = rvmls_pkg::F3_W;
                3:       row.f3 = rvmls_pkg::F3_BU;
                default: row.f3 = rvmls_pkg::F3_HU;
            endcase
        end
        else
        begin
            row.f3 = 3'($urandom_range(0, 7));
        end
        roll = $urandom_range(0, 99);
        if (roll < 45)
            row.addr = 32'($urandom_range(0, 63));
        else if (roll < 60)
            row.addr = 32'(rvmls_pkg::MEM_BYTES - 1 - $urandom_range(0, 63));
        else if (roll < 85)
            row.addr = 32'($urandom_range(0, rvmls_pkg::MEM_BYTES - 1));
        else
            row.addr = $urandom;
        row.wdata = $urandom;
        return row;
    endfunction

    task automatic send_access(input access_row_t row);
        int unsigned        gap;
        logic [31:0]        pred_value;
        rvmls_pkg::status_t pred_status;
        mem_result_t        expected;
        gap = draw_wait(sender_calm);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, row.wdata, row.addr, row.f3, row.cmd};
        do
            @(posedge clk);
        while (!s_tready);
        predict_access(row.cmd, row.f3, row.addr, row.wdata, pred_value, pred_status);
        if (row.fixed_exp)
        begin
            expected.value  = row.exp_value;
            expected.status = row.exp_status;
        end
        else
        begin
            expected.value  = pred_value;
            expected.status = pred_status;
        end
        expected_results.push_back(expected);
        status_count[pred_status]++;
        cmd_count[row.cmd]++;
        items_sent++;
        if (items_sent % MODE_SPAN == 0)
            sender_calm = ($urandom_range(0, 2) == 0);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result checker: every accepted result is matched against the oldest expectation.
    always @(posedge clk)
    begin
        mem_result_t expected;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("Unexpected result: load_value %h status %0d",
                             m_tdata[31:0], m_tdata[33:32]);
            end
            else
            begin
                expected = expected_results.pop_front();
                if (m_tdata[31:0] !== expected.value || m_tdata[33:32] !== expected.status)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"Mismatch on result %0d: load_value %h (expected %h), ",
                                  "status %0d (expected %0d)"},
                                 results_seen, m_tdata[31:0], expected.value,
                                 m_tdata[33:32], expected.status);
                end
            end
        end
    end

    initial
    begin : result_sink
        int unsigned stall;
        int unsigned taken;
        taken = 0;
        wait (rst_n);
        forever
        begin
            stall = draw_wait(receiver_calm);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            taken++;
            if (taken % MODE_SPAN == 0)
                receiver_calm = ($urandom_range(0, 2) == 0);
        end
    end

    initial
    begin : stimulus
        access_row_t directed_rows [N_DIRECTED];
        foreach (mem_image[i])
            mem_image[i] = 8'h00;
        foreach (status_count[i])
        begin
            status_count[i] = 0;
            cmd_count[i]    = 0;
        end

        // cmd, funct3, address, store data, expectation typed in, load_value, status
        directed_rows = '{
            // The memory reads as zero after the clearing pass.
            '{rvmls_pkg::CMD_LOAD,  rvmls_pkg::F3_W,  32'h0000_0000, 32'h0000_0000,
              1'b1, 32'h0, rvmls_pkg::ST_OK},
            '{rvmls_pkg::CMD_LOAD,  rvmls_pkg::F3_W,  32'h0000_0FFC, 32'h0000_0000,
              1'b1, 32'h0, rvmls_pkg::ST_OK},
            '{rvmls_pkg::CMD_STORE, rvmls_pkg::F3_W,  32'h0000_0000, 32'h8081_82F3,
              1'b1, 32'h0, rvmls_pkg::ST_OK},
            '{rvmls_pkg::CMD_LOAD,  rvmls_pkg::F3_B,  32'h0000_0000, 32'h0000_0000,
              1'b0, 32'h0, rvmls_pkg::ST_OK},
            '{rvmls_pkg::CMD_LOAD,  rvmls_pkg::F3_BU, 32'h0000_0000, 32'h0000_0000,
              1'b0, 32'h0, rvmls_pkg::ST_OK},
            '{rvmls_pkg::CMD_LOAD,  rvmls_pkg::F3_H,  32'h0000_0001, 32'h0000_0000,
              1'b0, 32'h0, rvmls_pkg::ST_OK},
            '{rvmls_pkg::CMD_LOAD,  rvmls_pkg::F3_HU, 32'h0000_0001, 32'h0000_0000,
              1'b0, 32'h0, rvmls_pkg::ST_OK},
            '{rvmls_pkg::CMD_LOAD,  rvmls_pkg::F3_W,  32'h0000_0003, 32'h0000_0000,
              1'b0, 32'h0, rvmls_pkg::ST_OK},
            // Top bytes of the memory, then accesses that run past the end.
            '{rvmls_pkg::CMD_STORE, rvmls_pkg::F3_B,  32'h0000_0FFF, 32'hFFFF_FFFF,
              1'b1, 32'h0, rvmls_pkg::ST_OK},
            '{rvmls_pkg::CMD_STORE, rvmls_pkg::F3_H,  32'h0000_0FFD, 32'h0000_7F01,
              1'b1, 32'h0, rvmls_pkg::ST_OK},
            '{rvmls_pkg::CMD_LOAD,  rvmls_pkg::F3_H,  32'h0000_0FFE, 32'h0000_0000,
              1'b0, 32'h0, rvmls_pkg::ST_OK},
            '{rvmls_pkg::CMD_LOAD,  rvmls_pkg::F3_W,  32'h0000_0FFC, 32'h0000_0000,
              1'b0, 32'h0, rvmls_pkg::ST_OK},
            '{rvmls_pkg::CMD_STORE, rvmls_pkg::F3_H,  32'h0000_0FFF, 32'h1234_5678,
              1'b1, 32'h0, rvmls_pkg::ST_RANGE},
            '{rvmls_pkg::CMD_STORE, rvmls_pkg::F3_W,  32'h0000_0FFD, 32'hFFFF_FFFF,
              1'b1, 32'h0, rvmls_pkg::ST_RANGE},
            '{rvmls_pkg::CMD_LOAD,  rvmls_pkg::F3_W,  32'h0000_0FFD, 32'h0000_0000,
              1'b1, 32'h0, rvmls_pkg::ST_RANGE},
            '{rvmls_pkg::CMD_LOAD,  rvmls_pkg::F3_B,  32'hFFFF_FFFF, 32'h0000_0000,
              1'b1, 32'h0, rvmls_pkg::ST_RANGE},
            // Width codes outside the supported set; funct3 wins over range.
            '{rvmls_pkg::CMD_LOAD,  F3_RSVD3,         32'h0000_0000, 32'h0000_0000,
              1'b1, 32'h0, rvmls_pkg::ST_FUNCT},
            '{rvmls_pkg::CMD_LOAD,  F3_RSVD6,         32'h0000_0010, 32'h0000_0000,
              1'b1, 32'h0, rvmls_pkg::ST_FUNCT},
            '{rvmls_pkg::CMD_LOAD,  F3_RSVD7,         32'hFFFF_FFFF, 32'h0000_0000,
              1'b1, 32'h0, rvmls_pkg::ST_FUNCT},
            '{rvmls_pkg::CMD_STORE, rvmls_pkg::F3_BU, 32'h0000_0000, 32'hFFFF_FFFF,
              1'b1, 32'h0, rvmls_pkg::ST_FUNCT},
            '{rvmls_pkg::CMD_STORE, rvmls_pkg::F3_HU, 32'h0000_0000, 32'hFFFF_FFFF,
              1'b1, 32'h0, rvmls_pkg::ST_FUNCT},
            // A conflict is reported ahead of every other check.
            '{rvmls_pkg::CMD_BOTH,  F3_RSVD7,         32'hFFFF_FFFF, 32'hFFFF_FFFF,
              1'b1, 32'h0, rvmls_pkg::ST_CONFLICT},
            '{rvmls_pkg::CMD_IDLE,  F3_RSVD7,         32'hFFFF_FFFF, 32'hFFFF_FFFF,
              1'b1, 32'h0, rvmls_pkg::ST_OK},
            // None of the refused stores above may have touched the memory.
            '{rvmls_pkg::CMD_LOAD,  rvmls_pkg::F3_W,  32'h0000_0000, 32'h0000_0000,
              1'b0, 32'h0, rvmls_pkg::ST_OK},
            '{rvmls_pkg::CMD_LOAD,  rvmls_pkg::F3_W,  32'h0000_0FFC, 32'h0000_0000,
              1'b0, 32'h0, rvmls_pkg::ST_OK}
        };

        wait (rst_n);
        @(posedge clk);
        foreach (directed_rows[i])
            send_access(directed_rows[i]);
        repeat (N_RANDOM)
            send_access(random_access());
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d transactions: %0d loads, %0d stores, %0d idle, %0d conflicts",
                 items_sent, cmd_count[rvmls_pkg::CMD_LOAD],
                 cmd_count[rvmls_pkg::CMD_STORE], cmd_count[rvmls_pkg::CMD_IDLE],
                 cmd_count[rvmls_pkg::CMD_BOTH]);
        $display({"Checked %0d results (ok %0d, range %0d, funct3 %0d, conflict %0d), ",
                  "%0d mismatches"},
                 results_seen, status_count[rvmls_pkg::ST_OK],
                 status_count[rvmls_pkg::ST_RANGE], status_count[rvmls_pkg::ST_FUNCT],
                 status_count[rvmls_pkg::ST_CONFLICT], mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
